/* design/bts_pkg.sv */
package bts_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FORMAT  = 3'd2;
    localparam logic [2:0] REG_SWIZZLE = 3'd3;
    localparam logic [2:0] REG_AMODES  = 3'd4;
    localparam logic [2:0] REG_FILTER  = 3'd5;
    localparam logic [2:0] REG_BASE    = 3'd6;
    localparam logic [2:0] REG_SLICES  = 3'd7;

    localparam logic [1:0] FMT_R8    = 2'd0;
    localparam logic [1:0] FMT_RGBA8 = 2'd1;
    localparam logic [1:0] FMT_BGRA8 = 2'd2;

    localparam logic [1:0] AM_REPEAT = 2'd0;
    localparam logic [1:0] AM_MIRROR = 2'd1;

    localparam logic [2:0] SW_ZERO = 3'd1;
    localparam logic [2:0] SW_ONE  = 3'd2;
    localparam logic [2:0] SW_R    = 3'd3;
    localparam logic [2:0] SW_G    = 3'd4;
    localparam logic [2:0] SW_B    = 3'd5;
    localparam logic [2:0] SW_A    = 3'd6;

    localparam logic [15:0] CH_ONE = 16'hFF00;

    localparam logic MODE_WRITE = 1'b0;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [1:0]  format;
        logic [11:0] swizzle;
        logic [3:0]  amodes;
        logic        linear;
        logic [7:0]  base;
        logic [8:0]  slices;
    } cfg_t;

    typedef struct packed {
        logic vld;
        logic wr;
    } ctl_t;

    typedef logic [3:0][7:0] chan_t;

    // Resolves one texel coordinate. c is the full coordinate, f is the same
    // coordinate reduced to the range -1 .. size, and par is the parity of
    // the integer part of the normalized coordinate.
    function automatic logic [12:0] wrap(input logic signed [22:0] c,
                                         input logic signed [14:0] f,
                                         input logic par,
                                         input logic [12:0] size,
                                         input logic [1:0] mode);
        logic signed [15:0] sz;
        logic signed [15:0] fe;
        logic signed [15:0] r;
        logic signed [15:0] m;
        logic [12:0] res;
        sz = $signed({3'b000, size});
        fe = f;
        r = '0;
        m = '0;
        res = '0;
        if (size == 13'd0)
        begin
            res = '0;
        end
        else if (mode == AM_REPEAT)
        begin
            if (fe < 0)
            begin
                r = fe + sz;
            end
            else if (fe >= sz)
            begin
                r = fe - sz;
            end
            else
            begin
                r = fe;
            end
            res = r[12:0];
        end
        else if (mode == AM_MIRROR)
        begin
            r = fe;
            if (par)
            begin
                r = fe + sz;
            end
            if (r < 0)
            begin
                r = r + sz + sz;
            end
            else if (r >= sz + sz)
            begin
                r = r - sz - sz;
            end
            m = sz + sz - 16'sd1 - r;
            res = (r < sz) ? r[12:0] : m[12:0];
        end
        else
        begin
            if (c < 0)
            begin
                res = '0;
            end
            else if (c >= sz)
            begin
                res = size - 13'd1;
            end
            else
            begin
                res = c[12:0];
            end
        end
        return res;
    endfunction

    function automatic chan_t decode(input logic [31:0] w, input logic [1:0] fmt);
        chan_t ch;
        ch = {8'hFF, 8'h00, 8'h00, 8'h00};
        unique case (fmt)
            FMT_R8:    ch[0] = w[7:0];
            FMT_RGBA8: ch = {w[31:24], w[23:16], w[15:8], w[7:0]};
            FMT_BGRA8: ch = {w[31:24], w[7:0], w[15:8], w[23:16]};
            default:   ch = {8'hFF, 8'h00, 8'h00, 8'h00};
        endcase
        return ch;
    endfunction

endpackage

/* design/bts_if.sv */
interface bts_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] texel_index;
    logic [31:0] texel_word;
    logic [23:0] coord_u;
    logic [23:0] coord_v;
    logic [15:0] coord_layer;

    modport source (output valid, mode, texel_index, texel_word, coord_u, coord_v,
                    coord_layer, input ready);
    modport sink (input valid, mode, texel_index, texel_word, coord_u, coord_v,
                  coord_layer, output ready);
endinterface

interface bts_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

/* design/bts_cfg.sv */
module bts_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]  paddr,
    input  logic [bts_pkg::PDATA_W-1:0]  pwdata,
    output logic [bts_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bts_pkg::cfg_t                cfg
);

    bts_pkg::cfg_t cfg_reg;
    logic [2:0] idx;
    logic wen;

    assign idx = paddr[4:2];
    assign wen = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width   <= 13'd1;
            cfg_reg.height  <= 13'd1;
            cfg_reg.format  <= bts_pkg::FMT_RGBA8;
            cfg_reg.swizzle <= '0;
            cfg_reg.amodes  <= '0;
            cfg_reg.linear  <= 1'b0;
            cfg_reg.base    <= '0;
            cfg_reg.slices  <= '0;
        end
        else if (wen)
        begin
            unique case (idx)
                bts_pkg::REG_WIDTH:   cfg_reg.width   <= pwdata[12:0];
                bts_pkg::REG_HEIGHT:  cfg_reg.height  <= pwdata[12:0];
                bts_pkg::REG_FORMAT:  cfg_reg.format  <= pwdata[1:0];
                bts_pkg::REG_SWIZZLE: cfg_reg.swizzle <= pwdata[11:0];
                bts_pkg::REG_AMODES:  cfg_reg.amodes  <= pwdata[3:0];
                bts_pkg::REG_FILTER:  cfg_reg.linear  <= pwdata[0];
                bts_pkg::REG_BASE:    cfg_reg.base    <= pwdata[7:0];
                bts_pkg::REG_SLICES:  cfg_reg.slices  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bts_pkg::REG_WIDTH:   prdata = 32'(cfg_reg.width);
            bts_pkg::REG_HEIGHT:  prdata = 32'(cfg_reg.height);
            bts_pkg::REG_FORMAT:  prdata = 32'(cfg_reg.format);
            bts_pkg::REG_SWIZZLE: prdata = 32'(cfg_reg.swizzle);
            bts_pkg::REG_AMODES:  prdata = 32'(cfg_reg.amodes);
            bts_pkg::REG_FILTER:  prdata = 32'(cfg_reg.linear);
            bts_pkg::REG_BASE:    prdata = 32'(cfg_reg.base);
            bts_pkg::REG_SLICES:  prdata = 32'(cfg_reg.slices);
            default:              prdata = '0;
        endcase
    end

endmodule

/* design/bts_addr.sv */
module bts_addr #(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  bts_pkg::cfg_t               cfg,
    input  logic                        req_vld,
    input  logic                        mode,
    input  logic [15:0]                 texel_index,
    input  logic [31:0]                 texel_word,
    input  logic [23:0]                 coord_u,
    input  logic [23:0]                 coord_v,
    input  logic [15:0]                 coord_layer,
    output bts_pkg::ctl_t               ctl,
    output logic [15:0]                 wr_idx,
    output logic [31:0]                 wr_word,
    output logic [35:0]                 row0,
    output logic [35:0]                 row1,
    output logic [12:0]                 x0,
    output logic [12:0]                 x1,
    output logic [WEIGHT_FRAC_BITS-1:0] wx,
    output logic [WEIGHT_FRAC_BITS-1:0] wy
);

    localparam int F = WEIGHT_FRAC_BITS;

    bts_pkg::ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic [15:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [31:0] s1_word_reg, s2_word_reg, s3_word_reg, s4_word_reg;

    // Stage 1: products and slice selection.
    logic signed [21:0] miu_next, miv_next;
    logic [28:0] mfu_next, mfv_next;
    logic signed [16:0] lay;
    logic signed [12:0] lidx;
    logic [8:0] cnt_m1;
    logic [8:0] sidx;
    logic [8:0] slice_next;
    logic signed [21:0] s1_miu_reg, s1_miv_reg;
    logic [28:0] s1_mfu_reg, s1_mfv_reg;
    logic s1_pu_reg, s1_pv_reg;
    logic [8:0] s1_slice_reg;

    assign miu_next = $signed(coord_u[23:16]) * $signed({1'b0, cfg.width});
    assign miv_next = $signed(coord_v[23:16]) * $signed({1'b0, cfg.height});
    assign mfu_next = coord_u[15:0] * cfg.width;
    assign mfv_next = coord_v[15:0] * cfg.height;
    assign lay = $signed(coord_layer) + 17'sd8;
    assign lidx = lay[16:4];
    assign cnt_m1 = cfg.slices - 9'd1;

    always_comb
    begin
        if (cfg.slices == 9'd0 || lidx < 0)
        begin
            sidx = '0;
        end
        else if (lidx > $signed({4'b0000, cnt_m1}))
        begin
            sidx = cnt_m1;
        end
        else
        begin
            sidx = lidx[8:0];
        end
        slice_next = {1'b0, cfg.base} + sidx;
    end

    // Stage 2: sample position split into integer and weight.
    logic signed [29:0] qu, qv;
    logic signed [14:0] fu_next, fv_next;
    logic signed [22:0] cu_next, cv_next;
    logic signed [14:0] s2_fu_reg, s2_fv_reg;
    logic signed [22:0] s2_cu_reg, s2_cv_reg;
    logic s2_pu_reg, s2_pv_reg;
    logic [F-1:0] s2_wx_reg, s2_wy_reg;
    logic [21:0] s2_sh_reg;

    assign qu = $signed({1'b0, s1_mfu_reg}) - (cfg.linear ? 30'sd32768 : 30'sd0);
    assign qv = $signed({1'b0, s1_mfv_reg}) - (cfg.linear ? 30'sd32768 : 30'sd0);
    assign fu_next = {qu[29], qu[29:16]};
    assign fv_next = {qv[29], qv[29:16]};
    assign cu_next = {s1_miu_reg[21], s1_miu_reg} + {{8{fu_next[14]}}, fu_next};
    assign cv_next = {s1_miv_reg[21], s1_miv_reg} + {{8{fv_next[14]}}, fv_next};

    // Stage 3: wrap, mirror or clamp.
    logic [12:0] s3_x0_reg, s3_x1_reg, s3_y0_reg, s3_y1_reg;
    logic [21:0] s3_sh_reg;
    logic [F-1:0] s3_wx_reg, s3_wy_reg;

    // Stage 4: row base addresses.
    logic [35:0] s4_row0_reg, s4_row1_reg;
    logic [12:0] s4_x0_reg, s4_x1_reg;
    logic [F-1:0] s4_wx_reg, s4_wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg.vld <= req_vld;
            s1_ctl_reg.wr  <= (mode == bts_pkg::MODE_WRITE);
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg   <= texel_index;
            s1_word_reg  <= texel_word;
            s1_miu_reg   <= miu_next;
            s1_miv_reg   <= miv_next;
            s1_mfu_reg   <= mfu_next;
            s1_mfv_reg   <= mfv_next;
            s1_pu_reg    <= coord_u[16];
            s1_pv_reg    <= coord_v[16];
            s1_slice_reg <= slice_next;

            s2_idx_reg  <= s1_idx_reg;
            s2_word_reg <= s1_word_reg;
            s2_fu_reg   <= fu_next;
            s2_fv_reg   <= fv_next;
            s2_cu_reg   <= cu_next;
            s2_cv_reg   <= cv_next;
            s2_pu_reg   <= s1_pu_reg;
            s2_pv_reg   <= s1_pv_reg;
            s2_wx_reg   <= cfg.linear ? qu[15:16-F] : '0;
            s2_wy_reg   <= cfg.linear ? qv[15:16-F] : '0;
            s2_sh_reg   <= s1_slice_reg * cfg.height;

            s3_idx_reg  <= s2_idx_reg;
            s3_word_reg <= s2_word_reg;
            s3_x0_reg <= bts_pkg::wrap(s2_cu_reg, s2_fu_reg, s2_pu_reg, cfg.width,
                                       cfg.amodes[1:0]);
            s3_x1_reg <= bts_pkg::wrap(s2_cu_reg + 23'sd1, s2_fu_reg + 15'sd1, s2_pu_reg,
                                       cfg.width, cfg.amodes[1:0]);
            s3_y0_reg <= bts_pkg::wrap(s2_cv_reg, s2_fv_reg, s2_pv_reg, cfg.height,
                                       cfg.amodes[3:2]);
            s3_y1_reg <= bts_pkg::wrap(s2_cv_reg + 23'sd1, s2_fv_reg + 15'sd1, s2_pv_reg,
                                       cfg.height, cfg.amodes[3:2]);
            s3_sh_reg <= s2_sh_reg;
            s3_wx_reg <= s2_wx_reg;
            s3_wy_reg <= s2_wy_reg;

            s4_idx_reg  <= s3_idx_reg;
            s4_word_reg <= s3_word_reg;
            s4_row0_reg <= ({1'b0, s3_sh_reg} + {10'b0, s3_y0_reg}) * cfg.width;
            s4_row1_reg <= ({1'b0, s3_sh_reg} + {10'b0, s3_y1_reg}) * cfg.width;
            s4_x0_reg   <= s3_x0_reg;
            s4_x1_reg   <= s3_x1_reg;
            s4_wx_reg   <= s3_wx_reg;
            s4_wy_reg   <= s3_wy_reg;
        end
    end

    assign ctl     = s4_ctl_reg;
    assign wr_idx  = s4_idx_reg;
    assign wr_word = s4_word_reg;
    assign row0    = s4_row0_reg;
    assign row1    = s4_row1_reg;
    assign x0      = s4_x0_reg;
    assign x1      = s4_x1_reg;
    assign wx      = s4_wx_reg;
    assign wy      = s4_wy_reg;

endmodule

/* design/bts_store.sv */
module bts_store #(
    parameter int STORE_DEPTH      = 65536,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  bts_pkg::ctl_t               ctl,
    input  logic [15:0]                 wr_idx,
    input  logic [31:0]                 wr_word,
    input  logic [35:0]                 row0,
    input  logic [35:0]                 row1,
    input  logic [12:0]                 x0,
    input  logic [12:0]                 x1,
    input  logic [WEIGHT_FRAC_BITS-1:0] wx,
    input  logic [WEIGHT_FRAC_BITS-1:0] wy,
    output logic                        smp_vld,
    output logic [3:0][31:0]            texels,
    output logic [WEIGHT_FRAC_BITS-1:0] wx_out,
    output logic [WEIGHT_FRAC_BITS-1:0] wy_out
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [3:0][36:0] sums;
    logic [3:0][AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic wen;
    logic vld_reg;
    logic [3:0][31:0] dat_reg;
    logic [WEIGHT_FRAC_BITS-1:0] wx_reg, wy_reg;
    logic [31:0] mem [4][STORE_DEPTH];

    // Port order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    assign sums[0] = {1'b0, row0} + {24'b0, x0};
    assign sums[1] = {1'b0, row0} + {24'b0, x1};
    assign sums[2] = {1'b0, row1} + {24'b0, x0};
    assign sums[3] = {1'b0, row1} + {24'b0, x1};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            raddr[i] = AW'(sums[i] % 37'(STORE_DEPTH));
        end
    end

    assign waddr = AW'(32'(wr_idx) % 32'(STORE_DEPTH));
    assign wen = adv && ctl.vld && ctl.wr;

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 4; g++)
        begin
            if (wen)
            begin
                mem[g][waddr] <= wr_word;
            end
            if (adv)
            begin
                dat_reg[g] <= mem[g][raddr[g]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= ctl.vld && !ctl.wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= wx;
            wy_reg <= wy;
        end
    end

    assign smp_vld = vld_reg;
    assign texels  = dat_reg;
    assign wx_out  = wx_reg;
    assign wy_out  = wy_reg;

endmodule

/* design/bts_filter.sv */
module bts_filter #(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  bts_pkg::cfg_t               cfg,
    input  logic                        smp_vld,
    input  logic [3:0][31:0]            texels,
    input  logic [WEIGHT_FRAC_BITS-1:0] wx,
    input  logic [WEIGHT_FRAC_BITS-1:0] wy,
    output logic                        out_vld,
    output logic [15:0]                 red,
    output logic [15:0]                 green,
    output logic [15:0]                 blue,
    output logic [15:0]                 alpha
);

    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int TW  = 8 + F;
    localparam int AW2 = 8 + 2 * F;
    localparam int DSH = 2 * F - 8;
    localparam logic [AW2-1:0] RND = (DSH > 0) ? AW2'(1) << (DSH - 1) : '0;
    localparam logic [F:0] S = (F + 1)'(1) << F;

    bts_pkg::chan_t c00, c10, c01, c11;
    logic [TW-1:0] iwx_e, wx_e;
    logic [3:0][TW-1:0] top_next, bot_next;

    logic f1_vld_reg;
    logic [3:0][TW-1:0] f1_top_reg, f1_bot_reg;
    logic [F-1:0] f1_wy_reg;

    logic [AW2-1:0] iwy_e, wy_e;
    logic [3:0][AW2-1:0] acc;
    logic [3:0][15:0] res_next;

    logic f2_vld_reg;
    logic [3:0][15:0] f2_res_reg;

    logic [3:0][15:0] swz_next;
    logic out_vld_reg;
    logic [3:0][15:0] out_reg;

    assign c00 = bts_pkg::decode(texels[0], cfg.format);
    assign c10 = bts_pkg::decode(texels[1], cfg.format);
    assign c01 = bts_pkg::decode(texels[2], cfg.format);
    assign c11 = bts_pkg::decode(texels[3], cfg.format);

    assign iwx_e = TW'(S - {1'b0, wx});
    assign wx_e  = TW'(wx);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            top_next[k] = TW'(c00[k]) * iwx_e + TW'(c10[k]) * wx_e;
            bot_next[k] = TW'(c01[k]) * iwx_e + TW'(c11[k]) * wx_e;
        end
    end

    assign iwy_e = AW2'(S - {1'b0, f1_wy_reg});
    assign wy_e  = AW2'(f1_wy_reg);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc[k] = AW2'(f1_top_reg[k]) * iwy_e + AW2'(f1_bot_reg[k]) * wy_e;
            res_next[k] = 16'((acc[k] + RND) >> DSH);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            unique case (cfg.swizzle[3*k +: 3])
                bts_pkg::SW_ZERO: swz_next[k] = '0;
                bts_pkg::SW_ONE:  swz_next[k] = bts_pkg::CH_ONE;
                bts_pkg::SW_R:    swz_next[k] = f2_res_reg[0];
                bts_pkg::SW_G:    swz_next[k] = f2_res_reg[1];
                bts_pkg::SW_B:    swz_next[k] = f2_res_reg[2];
                bts_pkg::SW_A:    swz_next[k] = f2_res_reg[3];
                default:          swz_next[k] = f2_res_reg[k];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg  <= smp_vld;
            f2_vld_reg  <= f1_vld_reg;
            out_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_top_reg <= top_next;
            f1_bot_reg <= bot_next;
            f1_wy_reg  <= wy;
            f2_res_reg <= res_next;
            out_reg    <= swz_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign red     = out_reg[0];
    assign green   = out_reg[1];
    assign blue    = out_reg[2];
    assign alpha   = out_reg[3];

endmodule

/* design/bilinear_texture_sampler.sv */
// A sample request passes the address stages, the store read register and the
// filter registers f1, f2 and out. Throughput: one request per cycle, writes and
// samples alike, while no valid response waits for rsp.ready; a write reaches
// the texel store after the address stages, in request order. The texel store is
// four replicated single-write memories, one read each. Reset (rst_n, asynchronous,
// active low) restores the register defaults and empties the pipeline; the texel store is not cleared.
module bilinear_texture_sampler #(
    parameter int STORE_DEPTH      = 65536,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bts_req_if.sink                      req,
    bts_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]  paddr,
    input  logic [bts_pkg::PDATA_W-1:0]  pwdata,
    output logic [bts_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    bts_pkg::cfg_t cfg;
    bts_pkg::ctl_t a_ctl;
    logic adv;
    logic [15:0] a_idx;
    logic [31:0] a_word;
    logic [35:0] a_row0, a_row1;
    logic [12:0] a_x0, a_x1;
    logic [WEIGHT_FRAC_BITS-1:0] a_wx, a_wy, m_wx, m_wy;
    logic m_vld;
    logic [3:0][31:0] m_texels;
    logic o_vld;

    assign adv = !o_vld || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = o_vld;

    bts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bts_addr #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .cfg         (cfg),
        .req_vld     (req.valid),
        .mode        (req.mode),
        .texel_index (req.texel_index),
        .texel_word  (req.texel_word),
        .coord_u     (req.coord_u),
        .coord_v     (req.coord_v),
        .coord_layer (req.coord_layer),
        .ctl         (a_ctl),
        .wr_idx      (a_idx),
        .wr_word     (a_word),
        .row0        (a_row0),
        .row1        (a_row1),
        .x0          (a_x0),
        .x1          (a_x1),
        .wx          (a_wx),
        .wy          (a_wy)
    );

    bts_store #(
        .STORE_DEPTH      (STORE_DEPTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl     (a_ctl),
        .wr_idx  (a_idx),
        .wr_word (a_word),
        .row0    (a_row0),
        .row1    (a_row1),
        .x0      (a_x0),
        .x1      (a_x1),
        .wx      (a_wx),
        .wy      (a_wy),
        .smp_vld (m_vld),
        .texels  (m_texels),
        .wx_out  (m_wx),
        .wy_out  (m_wy)
    );

    bts_filter #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg),
        .smp_vld (m_vld),
        .texels  (m_texels),
        .wx      (m_wx),
        .wy      (m_wy),
        .out_vld (o_vld),
        .red     (rsp.red),
        .green   (rsp.green),
        .blue    (rsp.blue),
        .alpha   (rsp.alpha)
    );

endmodule

/* bench/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_SAMPLE = ~bts_pkg::MODE_WRITE;
    localparam int   STALL_LIMIT = 4000;
    localparam int   PHASES = 13;
    localparam int   ITEMS_PER_PHASE = 94;
    localparam int   FILL_WORDS = 512;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } rgba_t;

    typedef struct {
        logic        mode;
        logic [15:0] index;
        logic [31:0] word;
        logic [23:0] u;
        logic [23:0] v;
        logic [15:0] layer;
        bit          known;
        rgba_t       result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bts_pkg::PADDR_W-1:0] paddr;
    logic [bts_pkg::PDATA_W-1:0] pwdata;
    logic [bts_pkg::PDATA_W-1:0] prdata;
    logic pready;

    bts_req_if req ();
    bts_rsp_if rsp ();

    bilinear_texture_sampler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [31:0]     texel_mem [0:65535];
    bts_pkg::cfg_t   tex_cfg;
    rgba_t           pending_colors[$];
    int              errors;
    int              gap_pct;
    int              stall_pct;
    int              idle_cycles;
    int              samples_seen;
    int              writes_sent;
    stim_row_t       dir_rows[10];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint wrap_axis(longint c, longint size, logic [1:0] m);
        longint r;
        longint p;
        if (size <= 0)
        begin
            return 0;
        end
        if (m == bts_pkg::AM_REPEAT)
        begin
            r = c % size;
            if (r < 0)
            begin
                r = r + size;
            end
            return r;
        end
        if (m == bts_pkg::AM_MIRROR)
        begin
            p = 2 * size;
            r = c % p;
            if (r < 0)
            begin
                r = r + p;
            end
            return (r < size) ? r : p - r - 1;
        end
        if (c < 0)
        begin
            return 0;
        end
        return (c > size - 1) ? size - 1 : c;
    endfunction

    function automatic bts_pkg::chan_t texel_at(longint slice, longint x, longint y);
        longint addr;
        logic [31:0] w;
        bts_pkg::chan_t ch;
        addr = (slice * tex_cfg.height + y) * tex_cfg.width + x;
        w = texel_mem[addr[15:0]];
        ch = {8'hFF, 8'h00, 8'h00, 8'h00};
        case (tex_cfg.format)
            bts_pkg::FMT_R8:    ch[0] = w[7:0];
            bts_pkg::FMT_RGBA8: ch = {w[31:24], w[23:16], w[15:8], w[7:0]};
            bts_pkg::FMT_BGRA8: ch = {w[31:24], w[7:0], w[15:8], w[23:16]};
            default:            ch = {8'hFF, 8'h00, 8'h00, 8'h00};
        endcase
        return ch;
    endfunction

    function automatic rgba_t filter_sample(logic [23:0] cu, logic [23:0] cv,
                                            logic [15:0] cl);
        longint u, v, l, w, h, slice, idx;
        longint px, py, x0, y0, wx, wy, ax0, ax1, ay0, ay1, top, bot;
        longint ch_val[4];
        longint outv[4];
        bts_pkg::chan_t c00, c10, c01, c11;
        logic [2:0] sel;
        rgba_t res;
        u = $signed(cu);
        v = $signed(cv);
        l = $signed(cl);
        w = tex_cfg.width;
        h = tex_cfg.height;
        if (tex_cfg.slices == 0)
        begin
            slice = tex_cfg.base;
        end
        else
        begin
            idx = (l + 8) >>> 4;
            if (idx < 0)
            begin
                idx = 0;
            end
            if (idx > tex_cfg.slices - 1)
            begin
                idx = tex_cfg.slices - 1;
            end
            slice = tex_cfg.base + idx;
        end
        if (!tex_cfg.linear)
        begin
            ax0 = wrap_axis((u * w) >>> 16, w, tex_cfg.amodes[1:0]);
            ay0 = wrap_axis((v * h) >>> 16, h, tex_cfg.amodes[3:2]);
            c00 = texel_at(slice, ax0, ay0);
            for (int k = 0; k < 4; k++)
            begin
                ch_val[k] = c00[k] * 256;
            end
        end
        else
        begin
            px = u * w - 32768;
            py = v * h - 32768;
            x0 = px >>> 16;
            y0 = py >>> 16;
            wx = (px - x0 * 65536) >>> 8;
            wy = (py - y0 * 65536) >>> 8;
            ax0 = wrap_axis(x0, w, tex_cfg.amodes[1:0]);
            ax1 = wrap_axis(x0 + 1, w, tex_cfg.amodes[1:0]);
            ay0 = wrap_axis(y0, h, tex_cfg.amodes[3:2]);
            ay1 = wrap_axis(y0 + 1, h, tex_cfg.amodes[3:2]);
            c00 = texel_at(slice, ax0, ay0);
            c10 = texel_at(slice, ax1, ay0);
            c01 = texel_at(slice, ax0, ay1);
            c11 = texel_at(slice, ax1, ay1);
            for (int k = 0; k < 4; k++)
            begin
                top = c00[k] * (256 - wx) + c10[k] * wx;
                bot = c01[k] * (256 - wx) + c11[k] * wx;
                ch_val[k] = (top * (256 - wy) + bot * wy + 128) >>> 8;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            sel = tex_cfg.swizzle[3 * k +: 3];
            case (sel)
                bts_pkg::SW_ZERO: outv[k] = 0;
                bts_pkg::SW_ONE:  outv[k] = bts_pkg::CH_ONE;
                bts_pkg::SW_R:    outv[k] = ch_val[0];
                bts_pkg::SW_G:    outv[k] = ch_val[1];
                bts_pkg::SW_B:    outv[k] = ch_val[2];
                bts_pkg::SW_A:    outv[k] = ch_val[3];
                default:          outv[k] = ch_val[k];
            endcase
        end
        res.red = outv[0][15:0];
        res.green = outv[1][15:0];
        res.blue = outv[2][15:0];
        res.alpha = outv[3][15:0];
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bts_pkg::PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bts_pkg::REG_WIDTH:   tex_cfg.width = val[12:0];
            bts_pkg::REG_HEIGHT:  tex_cfg.height = val[12:0];
            bts_pkg::REG_FORMAT:  tex_cfg.format = val[1:0];
            bts_pkg::REG_SWIZZLE: tex_cfg.swizzle = val[11:0];
            bts_pkg::REG_AMODES:  tex_cfg.amodes = val[3:0];
            bts_pkg::REG_FILTER:  tex_cfg.linear = val[0];
            bts_pkg::REG_BASE:    tex_cfg.base = val[7:0];
            default:              tex_cfg.slices = val[8:0];
        endcase
    endtask

    task automatic load_config(bts_pkg::cfg_t c);
        write_reg(bts_pkg::REG_WIDTH, 32'(c.width));
        write_reg(bts_pkg::REG_HEIGHT, 32'(c.height));
        write_reg(bts_pkg::REG_FORMAT, 32'(c.format));
        write_reg(bts_pkg::REG_SWIZZLE, 32'(c.swizzle));
        write_reg(bts_pkg::REG_AMODES, 32'(c.amodes));
        write_reg(bts_pkg::REG_FILTER, 32'(c.linear));
        write_reg(bts_pkg::REG_BASE, 32'(c.base));
        write_reg(bts_pkg::REG_SLICES, 32'(c.slices));
    endtask

    // Sends one request, and on acceptance updates the store copy or queues the color.
    task automatic send_request(stim_row_t row);
        while ($urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= row.mode;
        req.texel_index <= row.index;
        req.texel_word <= row.word;
        req.coord_u <= row.u;
        req.coord_v <= row.v;
        req.coord_layer <= row.layer;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        if (row.mode == bts_pkg::MODE_WRITE)
        begin
            texel_mem[row.index] = row.word;
            writes_sent++;
        end
        else if (row.known)
        begin
            pending_colors.push_back(row.result);
        end
        else
        begin
            pending_colors.push_back(filter_sample(row.u, row.v, row.layer));
        end
    endtask

    task automatic drain;
        req.valid <= 1'b0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(6 * 65536)) - 3 * 65536);
            2: return 24'($urandom_range(65535));
            default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    function automatic logic [12:0] pick_size();
        case ($urandom_range(9))
            0: return 13'd0;
            default: return 13'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        row.mode = ($urandom_range(99) < 30) ? bts_pkg::MODE_WRITE : MODE_SAMPLE;
        row.index = 16'($urandom_range(FILL_WORDS - 1));
        row.word = $urandom;
        row.u = pick_coord();
        row.v = pick_coord();
        row.layer = $urandom_range(1) ? 16'($urandom)
                                      : 16'(int'($urandom_range(4096)) - 2048);
        row.known = 1'b0;
        row.result = '0;
        return row;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        rgba_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            samples_seen++;
            if (pending_colors.size() == 0)
            begin
                $error("color returned with none outstanding");
                errors++;
            end
            else
            begin
                want = pending_colors.pop_front();
                check_field("red", want.red, rsp.red);
                check_field("green", want.green, rsp.green);
                check_field("blue", want.blue, rsp.blue);
                check_field("alpha", want.alpha, rsp.alpha);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        bts_pkg::cfg_t c;
        errors = 0;
        idle_cycles = 0;
        samples_seen = 0;
        writes_sent = 0;
        gap_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.mode = bts_pkg::MODE_WRITE;
        req.texel_index = '0;
        req.texel_word = '0;
        req.coord_u = '0;
        req.coord_v = '0;
        req.coord_layer = '0;
        rsp.ready = 1'b0;
        tex_cfg = '{width: 13'd1, height: 13'd1, format: bts_pkg::FMT_RGBA8,
                    swizzle: 12'd0, amodes: 4'd0, linear: 1'b0, base: 8'd0,
                    slices: 9'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the low words of the store; every texture below fetches only from them.
        for (int i = 0; i < FILL_WORDS; i++)
        begin
            row = '{bts_pkg::MODE_WRITE, 16'(i), $urandom, '0, '0, '0, 1'b0, '0};
            send_request(row);
        end

        // Reset configuration: a 1x1 RGBA8 texture, so every sample reads word 0.
        dir_rows[0] = '{bts_pkg::MODE_WRITE, 16'h0000, 32'h80FF0001, '0, '0, '0, 1'b0,
                        '0};
        dir_rows[1] = '{MODE_SAMPLE, '0, '0, 24'h000000, 24'h000000, 16'h0000, 1'b1,
                        '{16'h0100, 16'h0000, 16'hFF00, 16'h8000}};
        dir_rows[2] = '{MODE_SAMPLE, '0, '0, 24'h7FFFFF, 24'h800000, 16'h7FFF, 1'b1,
                        '{16'h0100, 16'h0000, 16'hFF00, 16'h8000}};
        dir_rows[3] = '{MODE_SAMPLE, '0, '0, 24'h800000, 24'h7FFFFF, 16'h8000, 1'b1,
                        '{16'h0100, 16'h0000, 16'hFF00, 16'h8000}};
        dir_rows[4] = '{bts_pkg::MODE_WRITE, 16'h0000, 32'hFFFFFFFF, '0, '0, '0, 1'b0,
                        '0};
        dir_rows[5] = '{MODE_SAMPLE, '0, '0, 24'hFFFFFF, 24'h010000, 16'hFFFF, 1'b1,
                        '{16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00}};
        dir_rows[6] = '{bts_pkg::MODE_WRITE, 16'h0000, 32'h00000000, '0, '0, '0, 1'b0,
                        '0};
        dir_rows[7] = '{MODE_SAMPLE, '0, '0, 24'h00FFFF, 24'hFF0000, 16'h0008, 1'b1,
                        '{16'h0000, 16'h0000, 16'h0000, 16'h0000}};
        dir_rows[8] = '{bts_pkg::MODE_WRITE, 16'hFFFF, 32'h12345678, '0, '0, '0, 1'b0,
                        '0};
        dir_rows[9] = '{MODE_SAMPLE, '0, '0, 24'h123456, 24'hABCDEF, 16'h5A5A, 1'b0, '0};
        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i]);
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
            begin
                gap_pct = 30;
                stall_pct = 79;
            end
            else if (p < 8)
            begin
                gap_pct = 79;
                stall_pct = 30;
            end
            else
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            if (p == 0)
            begin
                c = '{width: 13'd0, height: 13'd8191, format: 2'd3, swizzle: 12'd0,
                      amodes: 4'd0, linear: 1'b0, base: 8'd0, slices: 9'd0};
            end
            else if (p == 1)
            begin
                c = '{width: 13'd0, height: 13'd4096, format: bts_pkg::FMT_R8,
                      swizzle: 12'hFFF, amodes: 4'hF, linear: 1'b1, base: 8'd255,
                      slices: 9'd256};
            end
            else if (p == 2)
            begin
                c = '{width: 13'd8, height: 13'd3, format: bts_pkg::FMT_BGRA8,
                      swizzle: 12'o6543, amodes: 4'b0101, linear: 1'b1, base: 8'd7,
                      slices: 9'd4};
            end
            else
            begin
                // Small sizes, base and slice count keep every fetch in the filled words.
                c.width = pick_size();
                c.height = pick_size();
                c.format = 2'($urandom);
                c.swizzle = 12'($urandom);
                c.amodes = 4'($urandom);
                c.linear = 1'($urandom);
                c.base = 8'($urandom_range(3));
                c.slices = 9'($urandom_range(4));
            end
            load_config(c);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_request(random_row());
            end
            drain();
        end

        $display("Covered %0d texel writes and %0d checked samples over %0d settings,",
                 writes_sent, samples_seen, PHASES + 1);
        $display("including zero and oversize textures, all formats, wraps and swizzles.");
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
design/bts_pkg.sv
design/bts_if.sv
design/bts_cfg.sv
design/bts_addr.sv
design/bts_store.sv
design/bts_filter.sv
design/bilinear_texture_sampler.sv
bench/testbench.sv
